>>> rtl/core/scheduled_led_fade_engine_macros.svh
// Assertion macros used by the checker file of the LED fade engine.
`ifndef SCHEDULED_LED_FADE_ENGINE_MACROS_SVH
`define SCHEDULED_LED_FADE_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> rtl/core/sfe_pkg.sv
// Package of the LED fade engine: sizes, codes, and shared structures.
package sfe_pkg;

  localparam int CHANNELS   = 5;
  localparam int POINTS     = 16;
  localparam int CH_IW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PT_IW      = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int MEM_DEPTH  = POINTS * CHANNELS;
  localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int MIN_PER_HOUR = 60;
  localparam int DUTY_FULL    = 255;
  // Reciprocal of DUTY_FULL scaled by two to the RECIP_SHIFT, rounded up.
  localparam int RECIP_SHIFT  = 23;
  localparam int RECIP_255    = ((1 << RECIP_SHIFT) + DUTY_FULL - 1) / DUTY_FULL;

  localparam logic [15:0] MAX_PWM_RESET    = 16'd5000;
  localparam logic [7:0]  FADE_STEPS_RESET = 8'd50;

  // Operation codes of the input item.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_TIME    = 3'd1;
  localparam logic [2:0] OP_SET     = 3'd2;
  localparam logic [2:0] OP_PT_TIME = 3'd3;
  localparam logic [2:0] OP_PT_DUTY = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_MAX_PWM    = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_FADE_STEPS = 1'd1;

  typedef struct packed {
    logic       en;
    logic [4:0] hour;
    logic [5:0] minute;
  } pt_time_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             cap;
    logic             set_duty;
    logic             wr_time;
    logic             wr_pdut;
    logic             ld_rd;
    logic             ld_wr;
    logic             arm;
    logic             clr_left;
    logic             step;
    logic             div_ld;
    logic             tick_end;
    logic             out_ld;
    logic [PT_IW-1:0] pt;
    logic [CH_IW-1:0] ch;
    logic             last;
  } sfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       sec_zero;
    logic       armed;
    logic       has_steps;
    logic       steps_one;
    logic       match;
    logic       div_done;
    logic       out_busy;
  } sfe_stat_t;

endpackage

>>> rtl/core/sfe_ifs.sv
// Channel interfaces of the LED fade engine: input items, results, configuration.
interface sfe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [4:0] clock_hour;
  logic [5:0] clock_minute;
  logic [5:0] now_second;
  logic [2:0] channel;
  logic [7:0] duty;
  logic [3:0] point_index;
  logic       point_enabled;
  modport source (output valid, op, clock_hour, clock_minute, now_second, channel, duty,
                  point_index, point_enabled, input ready);
  modport sink (input valid, op, clock_hour, clock_minute, now_second, channel, duty,
                point_index, point_enabled, output ready);
endinterface

interface sfe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_channel;
  logic [15:0] pwm_duty;
  logic        last_channel;
  logic        fade_done;
  modport source (output valid, out_channel, pwm_duty, last_channel, fade_done,
                  input ready);
  modport sink (input valid, out_channel, pwm_duty, last_channel, fade_done,
                output ready);
endinterface

interface sfe_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sfe_pkg::CFG_IW-1:0] index;
  logic [15:0]                data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/sfe_div.sv
// Restoring divider of an 8-bit magnitude by a 9-bit divisor, one bit per cycle.
module sfe_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] num_i,
  input  logic [8:0] den_i,
  output logic       done_o,
  output logic [7:0] quo_o,
  output logic       rem_nz_o
);

  logic [8:0] rem_q, rem_d;
  logic [7:0] quo_q;
  logic [8:0] den_q;
  logic [3:0] cnt_q;
  logic       busy_q, done_q;
  logic [9:0] trial;
  logic       ge;

  // One quotient bit: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q, quo_q[7]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? 9'(trial - {1'b0, den_q}) : trial[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd8;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand registers need no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 9'd0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[6:0], ge};
    end
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = (rem_q != 9'd0);

endmodule

>>> rtl/core/sfe_datapath.sv
// Datapath of the LED fade engine: channel state, schedule stores, divider, PWM scaling.
module sfe_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  sfe_in_if.sink             in_if,
  sfe_out_if.source          out_if,
  sfe_cfg_if.sink            cfg_if,
  input  sfe_pkg::sfe_cmd_t  cmd_i,
  output sfe_pkg::sfe_stat_t stat_o
);

  // Captured input item.
  logic [2:0] op_q;
  logic [4:0] hour_q;
  logic [5:0] minute_q, second_q;
  logic [2:0] chan_q;
  logic [7:0] duty_q;
  logic [3:0] pidx_q;
  logic       pen_q;

  logic [15:0] max_pwm_q;
  logic [7:0]  fade_steps_q;

  logic [7:0] cur_q   [sfe_pkg::CHANNELS];
  logic [7:0] tgt_q   [sfe_pkg::CHANNELS];
  logic [7:0] steps_q [sfe_pkg::CHANNELS];
  logic       armed_q, left_q, done_q, neg_q;

  sfe_pkg::pt_time_t pt_time_q [sfe_pkg::POINTS];
  logic [7:0] duty_mem [sfe_pkg::MEM_DEPTH];
  logic [7:0] rdata_q;

  logic [23:0] prod_q;
  logic [16:0] est_q;
  logic [15:0] pwm_q;

  logic        out_valid_q;
  logic [2:0]  out_chan_q;
  logic [15:0] out_pwm_q;
  logic        out_last_q, out_done_q;

  logic                      ch_ok, pt_ok;
  logic [sfe_pkg::CH_IW-1:0] in_ch;
  logic [sfe_pkg::PT_IW-1:0] in_pt;
  logic [sfe_pkg::MEM_AW-1:0] wr_addr, rd_addr;
  logic [10:0] now_min, pt_min;
  logic [7:0]  cur_k, tgt_k;
  logic [8:0]  diff;
  logic [7:0]  mag;
  logic        div_done, rem_nz;
  logic [7:0]  quo;
  logic [7:0]  div_cur;
  logic        any_diff;
  logic        left_nx;
  logic [39:0] est_full;
  logic [24:0] est_x255;

  // Input decoding and addressing.
  always_comb begin
    in_ch   = sfe_pkg::CH_IW'(chan_q);
    in_pt   = sfe_pkg::PT_IW'(pidx_q);
    ch_ok   = ({1'b0, chan_q} < 4'(sfe_pkg::CHANNELS));
    pt_ok   = ({3'b0, pidx_q} < 7'(sfe_pkg::POINTS));
    wr_addr = sfe_pkg::MEM_AW'(sfe_pkg::MEM_AW'(in_pt) * sfe_pkg::MEM_AW'(sfe_pkg::CHANNELS)
              + sfe_pkg::MEM_AW'(in_ch));
    rd_addr = sfe_pkg::MEM_AW'(sfe_pkg::MEM_AW'(cmd_i.pt)
              * sfe_pkg::MEM_AW'(sfe_pkg::CHANNELS) + sfe_pkg::MEM_AW'(cmd_i.ch));
    now_min = 11'(hour_q) * 11'(sfe_pkg::MIN_PER_HOUR) + 11'(minute_q);
    pt_min  = 11'(pt_time_q[cmd_i.pt].hour) * 11'(sfe_pkg::MIN_PER_HOUR)
              + 11'(pt_time_q[cmd_i.pt].minute);
  end

  // Step toward the target: signed difference split into sign and magnitude.
  always_comb begin
    cur_k = cur_q[cmd_i.ch];
    tgt_k = tgt_q[cmd_i.ch];
    diff  = {1'b0, tgt_k} - {1'b0, cur_k};
    mag   = diff[8] ? 8'(-diff) : diff[7:0];
    // Floor division rounds a negative quotient down when a remainder is left.
    div_cur = neg_q ? 8'(cur_k - quo - {7'd0, rem_nz}) : 8'(cur_k + quo);
  end

  sfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.step && (steps_q[cmd_i.ch] > 8'd1)),
    .num_i   (mag),
    .den_i   ({1'b0, steps_q[cmd_i.ch]}),
    .done_o  (div_done),
    .quo_o   (quo),
    .rem_nz_o(rem_nz)
  );

  always_comb begin
    any_diff = 1'b0;
    for (int k = 0; k < sfe_pkg::CHANNELS; k++) begin
      if (cur_q[k] != tgt_q[k]) any_diff = 1'b1;
    end
  end

  // Steps-left flag including the channel being stepped in this cycle.
  always_comb begin
    if (cmd_i.step && (steps_q[cmd_i.ch] != 8'd0)) begin
      left_nx = (steps_q[cmd_i.ch] != 8'd1);
    end else begin
      left_nx = left_q;
    end
  end

  // Item capture and the point duty memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q     <= in_if.op;
      hour_q   <= in_if.clock_hour;
      minute_q <= in_if.clock_minute;
      second_q <= in_if.now_second;
      chan_q   <= in_if.channel;
      duty_q   <= in_if.duty;
      pidx_q   <= in_if.point_index;
      pen_q    <= in_if.point_enabled;
    end
    if (cmd_i.wr_pdut && ch_ok && pt_ok) duty_mem[wr_addr] <= duty_q;
    if (cmd_i.ld_rd) rdata_q <= duty_mem[rd_addr];
    if (cmd_i.step) neg_q <= diff[8];
  end

  // Configuration, channel and schedule state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pwm_q    <= sfe_pkg::MAX_PWM_RESET;
      fade_steps_q <= sfe_pkg::FADE_STEPS_RESET;
      armed_q      <= 1'b0;
      left_q       <= 1'b0;
      done_q       <= 1'b0;
      for (int k = 0; k < sfe_pkg::CHANNELS; k++) begin
        cur_q[k]   <= 8'd0;
        tgt_q[k]   <= 8'd0;
        steps_q[k] <= 8'd0;
      end
      for (int j = 0; j < sfe_pkg::POINTS; j++) begin
        pt_time_q[j] <= '0;
      end
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.index)
          sfe_pkg::CFG_MAX_PWM:    max_pwm_q    <= cfg_if.data;
          sfe_pkg::CFG_FADE_STEPS: fade_steps_q <= cfg_if.data[7:0];
          default: ;
        endcase
      end
      if (cmd_i.set_duty && ch_ok) begin
        tgt_q[in_ch]   <= duty_q;
        steps_q[in_ch] <= (duty_q != cur_q[in_ch]) ? fade_steps_q : 8'd1;
      end
      if (cmd_i.wr_time && pt_ok) begin
        pt_time_q[in_pt] <= '{en: pen_q, hour: hour_q, minute: minute_q};
      end
      if (cmd_i.ld_wr) begin
        tgt_q[cmd_i.ch]   <= rdata_q;
        steps_q[cmd_i.ch] <= fade_steps_q;
      end
      if (cmd_i.arm && any_diff) armed_q <= 1'b1;
      if (cmd_i.clr_left) left_q <= 1'b0;
      if (cmd_i.step && (steps_q[cmd_i.ch] != 8'd0)) begin
        steps_q[cmd_i.ch] <= steps_q[cmd_i.ch] - 8'd1;
        if (steps_q[cmd_i.ch] == 8'd1) begin
          cur_q[cmd_i.ch] <= tgt_k;
          left_q          <= 1'b0;
        end else begin
          left_q <= 1'b1;
        end
      end
      if (cmd_i.div_ld) cur_q[cmd_i.ch] <= div_cur;
      if (cmd_i.tick_end) begin
        done_q <= !left_nx;
        if (!left_nx) armed_q <= 1'b0;
      end
    end
  end

  // PWM scaling: product, reciprocal estimate, then a one-step correction.
  always_comb begin
    est_full = 40'(prod_q) * 40'(sfe_pkg::RECIP_255);
    est_x255 = {est_q, 8'd0} - 25'(est_q);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 24'(cur_q[cmd_i.ch]) * 24'(max_pwm_q);
    est_q  <= 17'(est_full >> sfe_pkg::RECIP_SHIFT);
    pwm_q  <= (est_x255 > 25'(prod_q)) ? 16'(est_q - 17'd1) : est_q[15:0];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_chan_q <= 3'(cmd_i.ch);
      out_pwm_q  <= pwm_q;
      out_last_q <= cmd_i.last;
      out_done_q <= cmd_i.last && done_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.out_channel  = out_chan_q;
  assign out_if.pwm_duty     = out_pwm_q;
  assign out_if.last_channel = out_last_q;
  assign out_if.fade_done    = out_done_q;
  assign cfg_if.ready        = 1'b1;

  always_comb begin
    stat_o.op        = op_q;
    stat_o.sec_zero  = (second_q == 6'd0);
    stat_o.armed     = armed_q;
    stat_o.has_steps = (steps_q[cmd_i.ch] != 8'd0);
    stat_o.steps_one = (steps_q[cmd_i.ch] == 8'd1);
    stat_o.match     = pt_time_q[cmd_i.pt].en && (pt_min == now_min);
    stat_o.div_done  = div_done;
    stat_o.out_busy  = out_valid_q && !out_if.ready;
  end

endmodule

>>> rtl/core/sfe_ctrl.sv
// Controller of the LED fade engine: sequences each item over channels and points.
module sfe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sfe_pkg::sfe_stat_t stat_i,
  output sfe_pkg::sfe_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SCAN, S_LDRD, S_LDWR, S_ARM, S_STEP, S_DIV, S_WAIT, S_OUT
  } state_e;

  localparam logic [sfe_pkg::CH_IW-1:0] CH_LAST = sfe_pkg::CH_IW'(sfe_pkg::CHANNELS - 1);
  localparam logic [sfe_pkg::PT_IW-1:0] PT_LAST = sfe_pkg::PT_IW'(sfe_pkg::POINTS - 1);

  state_e                    state_q;
  logic [sfe_pkg::CH_IW-1:0] k_q;
  logic [sfe_pkg::PT_IW-1:0] j_q;
  logic [1:0]                wait_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Commands follow from the state and the datapath status.
  always_comb begin
    cmd_o          = '0;
    cmd_o.pt       = j_q;
    cmd_o.ch       = k_q;
    cmd_o.last     = (k_q == CH_LAST);
    cmd_o.cap      = in_valid_i && (state_q == S_IDLE);
    case (state_q)
      S_DISP: begin
        cmd_o.set_duty = (stat_i.op == sfe_pkg::OP_SET);
        cmd_o.wr_time  = (stat_i.op == sfe_pkg::OP_PT_TIME);
        cmd_o.wr_pdut  = (stat_i.op == sfe_pkg::OP_PT_DUTY);
        cmd_o.clr_left = (stat_i.op == sfe_pkg::OP_TICK);
      end
      S_LDRD: cmd_o.ld_rd = 1'b1;
      S_LDWR: cmd_o.ld_wr = 1'b1;
      S_ARM:  cmd_o.arm   = 1'b1;
      S_STEP: begin
        cmd_o.step     = 1'b1;
        cmd_o.tick_end = (k_q == CH_LAST) && !(stat_i.has_steps && !stat_i.steps_one);
      end
      S_DIV: begin
        cmd_o.div_ld   = stat_i.div_done;
        cmd_o.tick_end = stat_i.div_done && (k_q == CH_LAST);
      end
      S_OUT:  cmd_o.out_ld = !stat_i.out_busy;
      default: ;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      wait_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DISP;
        end
        S_DISP: begin
          k_q <= '0;
          j_q <= '0;
          case (stat_i.op)
            sfe_pkg::OP_TICK: state_q <= stat_i.armed ? S_STEP : S_IDLE;
            sfe_pkg::OP_TIME: state_q <= stat_i.sec_zero ? S_SCAN : S_ARM;
            default:          state_q <= S_IDLE;
          endcase
        end
        S_SCAN: begin
          if (stat_i.match) begin
            k_q     <= '0;
            state_q <= S_LDRD;
          end else if (j_q == PT_LAST) begin
            state_q <= S_ARM;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_LDRD: state_q <= S_LDWR;
        S_LDWR: begin
          if (k_q != CH_LAST) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_LDRD;
          end else if (j_q == PT_LAST) begin
            state_q <= S_ARM;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_ARM: state_q <= S_IDLE;
        S_STEP: begin
          if (stat_i.has_steps && !stat_i.steps_one) begin
            state_q <= S_DIV;
          end else if (k_q == CH_LAST) begin
            k_q     <= '0;
            wait_q  <= '0;
            state_q <= S_WAIT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_DIV: begin
          if (stat_i.div_done) begin
            if (k_q == CH_LAST) begin
              k_q     <= '0;
              wait_q  <= '0;
              state_q <= S_WAIT;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_STEP;
            end
          end
        end
        // The scaling pipeline is three registers deep.
        S_WAIT: begin
          wait_q <= wait_q + 2'd1;
          if (wait_q == 2'd2) state_q <= S_OUT;
        end
        S_OUT: begin
          if (!stat_i.out_busy) begin
            if (k_q == CH_LAST) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              wait_q  <= '0;
              state_q <= S_WAIT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/scheduled_led_fade_engine.sv
// Top level of the scheduled LED fade engine.
//
//   channel   direction  carries
//   in_if     sink       op, time fields, channel, duty, point fields
//   out_if    source     out_channel, pwm_duty, last_channel, fade_done
//   cfg_if    sink       index, data (0 max_pwm, 1 fade_steps)
//
// Set-duty and point writes finish in dispatch; a time event at second zero
// scans every point and loads all channels for each matching point, else only arms.
// An active fade tick steps every channel, running the serial divider for each one
// with more than one step left, then passes each result through the scaling pipeline.
// A result waits in the output register; a stalled sink holds the next result back.
// Reset clears all channel state and schedule times; it needs no clearing pass.
module scheduled_led_fade_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfe_in_if.sink    in_if,
  sfe_out_if.source out_if,
  sfe_cfg_if.sink   cfg_if
);

  sfe_pkg::sfe_cmd_t  cmd;
  sfe_pkg::sfe_stat_t stat;

  sfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfe_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

>>> rtl/core/sfe_checker.sv
// Port-level checker of the LED fade engine and its bind to the top level.
`include "scheduled_led_fade_engine_macros.svh"

module sfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_channel_i,
  input logic       last_channel_i,
  input logic       fade_done_i
);

  localparam logic [2:0] CH_LAST = 3'(sfe_pkg::CHANNELS - 1);

  // A stalled result keeps its place.
  `SFE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_channel_i))
  // The done flag only rides on the final result of a tick.
  `SFE_ASSERT_NOW(a_done_last, clk_i, rst_ni, out_valid_i && fade_done_i, last_channel_i)
  // The final result is exactly the highest channel.
  `SFE_ASSERT_NOW(a_last_chan, clk_i, rst_ni, out_valid_i, last_channel_i == (out_channel_i == CH_LAST))

endmodule

bind scheduled_led_fade_engine sfe_checker u_sfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .out_channel_i  (out_if.out_channel),
  .last_channel_i (out_if.last_channel),
  .fade_done_i    (out_if.fade_done)
);

>>> tb/tb.sv
// Self-checking testbench of the scheduled LED fade engine with scoreboard and stimulus.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One input transaction as the sender offers it.
  typedef struct {
    logic [2:0] op;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] channel;
    logic [7:0] duty;
    logic [3:0] point;
    logic       enabled;
  } fade_cmd_t;

  // One PWM report of a fade tick.
  typedef struct {
    logic [2:0]  channel;
    logic [15:0] pwm;
    logic        last;
    logic        done;
  } pwm_report_t;

  // Tracks the fader state and the PWM reports that the fade ticks must produce.
  class fade_scoreboard;
    logic [15:0]       max_pwm;
    logic [7:0]        fade_steps;
    logic [7:0]        level [sfe_pkg::CHANNELS];
    logic [7:0]        target [sfe_pkg::CHANNELS];
    logic [7:0]        left [sfe_pkg::CHANNELS];
    logic              armed;
    sfe_pkg::pt_time_t sched_time [sfe_pkg::POINTS];
    logic [7:0]        sched_duty [sfe_pkg::POINTS*sfe_pkg::CHANNELS];
    pwm_report_t       pending_reports[$];
    int                errors;
    int                reports_seen;
    int                active_ticks;
    int                loads;

    function new();
      max_pwm    = sfe_pkg::MAX_PWM_RESET;
      fade_steps = sfe_pkg::FADE_STEPS_RESET;
      armed      = 1'b0;
      errors     = 0;
      reports_seen = 0;
      active_ticks = 0;
      loads      = 0;
      for (int k = 0; k < sfe_pkg::CHANNELS; k++) begin
        level[k] = '0;
        target[k] = '0;
        left[k] = '0;
      end
      for (int j = 0; j < sfe_pkg::POINTS; j++) sched_time[j] = '0;
      for (int j = 0; j < sfe_pkg::POINTS*sfe_pkg::CHANNELS; j++) sched_duty[j] = '0;
    endfunction

    function void write_reg(logic [sfe_pkg::CFG_IW-1:0] idx, logic [15:0] data);
      if (idx == sfe_pkg::CFG_MAX_PWM) max_pwm = data;
      else if (idx == sfe_pkg::CFG_FADE_STEPS) fade_steps = data[7:0];
    endfunction

    // Floor of the remaining distance split over steps plus one.
    function logic [7:0] move_toward(logic [7:0] cur, logic [7:0] tgt, logic [7:0] steps);
      int diff;
      int div;
      int q;
      diff = int'(tgt) - int'(cur);
      div  = int'(steps) + 1;
      q    = diff / div;
      if (diff < 0 && (diff % div) != 0) q = q - 1;
      return 8'(int'(cur) + q);
    endfunction

    function void note(fade_cmd_t c);
      int last_left;
      int now_min;
      logic done;
      pwm_report_t r;
      case (c.op)
        sfe_pkg::OP_TICK: begin
          if (armed) begin
            active_ticks++;
            last_left = 0;
            for (int k = 0; k < sfe_pkg::CHANNELS; k++) begin
              if (left[k] != 0) begin
                left[k] = left[k] - 1;
                if (left[k] == 0) level[k] = target[k];
                else level[k] = move_toward(level[k], target[k], left[k]);
                last_left = left[k];
              end
            end
            done = (last_left == 0);
            if (done) armed = 1'b0;
            for (int k = 0; k < sfe_pkg::CHANNELS; k++) begin
              r.channel = 3'(k);
              r.pwm     = 16'((32'(level[k]) * 32'(max_pwm)) / sfe_pkg::DUTY_FULL);
              r.last    = (k == sfe_pkg::CHANNELS - 1);
              r.done    = r.last && done;
              pending_reports.push_back(r);
            end
          end
        end
        sfe_pkg::OP_TIME: begin
          if (c.second == 0) begin
            now_min = int'(c.hour) * sfe_pkg::MIN_PER_HOUR + int'(c.minute);
            for (int j = 0; j < sfe_pkg::POINTS; j++) begin
              if (sched_time[j].en && (int'(sched_time[j].hour) * sfe_pkg::MIN_PER_HOUR +
                  int'(sched_time[j].minute)) == now_min) begin
                loads++;
                for (int k = 0; k < sfe_pkg::CHANNELS; k++) begin
                  target[k] = sched_duty[j*sfe_pkg::CHANNELS + k];
                  left[k]   = fade_steps;
                end
              end
            end
          end
          for (int k = 0; k < sfe_pkg::CHANNELS; k++)
            if (level[k] != target[k]) armed = 1'b1;
        end
        sfe_pkg::OP_SET: begin
          if (c.channel < sfe_pkg::CHANNELS) begin
            target[c.channel] = c.duty;
            left[c.channel] = (c.duty != level[c.channel]) ? fade_steps : 8'd1;
          end
        end
        sfe_pkg::OP_PT_TIME: begin
          if (c.point < sfe_pkg::POINTS) sched_time[c.point] = {c.enabled, c.hour, c.minute};
        end
        sfe_pkg::OP_PT_DUTY: begin
          if (c.point < sfe_pkg::POINTS && c.channel < sfe_pkg::CHANNELS)
            sched_duty[int'(c.point)*sfe_pkg::CHANNELS + int'(c.channel)] = c.duty;
        end
        default: ;
      endcase
    endfunction

    function void check(pwm_report_t got);
      pwm_report_t exp_r;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("unexpected PWM report: channel %0d pwm %0d", got.channel, got.pwm);
        errors++;
        return;
      end
      exp_r = pending_reports.pop_front();
      if (got.channel !== exp_r.channel) begin
        $error("out_channel: expected %0d, got %0d", exp_r.channel, got.channel);
        errors++;
      end
      if (got.pwm !== exp_r.pwm) begin
        $error("pwm_duty: expected %0d, got %0d", exp_r.pwm, got.pwm);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_channel: expected %0b, got %0b", exp_r.last, got.last);
        errors++;
      end
      if (got.done !== exp_r.done) begin
        $error("fade_done: expected %0b, got %0b", exp_r.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sfe_in_if  in_if ();
  sfe_out_if out_if ();
  sfe_cfg_if cfg_if ();

  scheduled_led_fade_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  fade_scoreboard sb;
  logic           no_idle;
  logic           hold_req;
  int             items_sent;
  // Which point duties have been written, so only fully written points get enabled.
  logic           duty_written [sfe_pkg::POINTS][sfe_pkg::CHANNELS];

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Check every result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check('{out_if.out_channel, out_if.pwm_duty, out_if.last_channel, out_if.fade_done});
    end
  end

  // Receiver: random stalls, one long hold-off on request, none while no_idle is set.
  initial begin : receiver
    int hold_cnt;
    logic hold_done;
    hold_cnt = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // Offer one input transaction and record it once accepted; valid stays high unless a random gap follows.
  task automatic send(fade_cmd_t c);
    in_if.valid         <= 1'b1;
    in_if.op            <= c.op;
    in_if.clock_hour    <= c.hour;
    in_if.clock_minute  <= c.minute;
    in_if.now_second    <= c.second;
    in_if.channel       <= c.channel;
    in_if.duty          <= c.duty;
    in_if.point_index   <= c.point;
    in_if.point_enabled <= c.enabled;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note(c);
    items_sent++;
    if (c.op == sfe_pkg::OP_PT_DUTY && c.channel < sfe_pkg::CHANNELS)
      duty_written[c.point][c.channel] = 1'b1;
    if (!no_idle && $urandom_range(0, 99) < 36) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  function automatic fade_cmd_t mk(logic [2:0] op, logic [4:0] h, logic [5:0] m,
                                   logic [5:0] s, logic [2:0] ch, logic [7:0] d,
                                   logic [3:0] pt, logic en);
    fade_cmd_t c;
    c = '{op, h, m, s, ch, d, pt, en};
    return c;
  endfunction

  // Point time write; a point is only enabled once all its duties are written.
  function automatic fade_cmd_t mk_point_time(logic [3:0] pt, logic [4:0] h, logic [5:0] m,
                                              logic en);
    logic full;
    full = 1'b1;
    for (int k = 0; k < sfe_pkg::CHANNELS; k++) full &= duty_written[pt][k];
    return mk(sfe_pkg::OP_PT_TIME, h, m, 6'($urandom), 3'($urandom), 8'($urandom), pt,
              en & full);
  endfunction

  // Random transaction, mostly well-formed schedule traffic and fade ticks.
  function automatic fade_cmd_t rand_cmd();
    int sel;
    int pt;
    fade_cmd_t c;
    sel = $urandom_range(0, 99);
    c = mk(3'($urandom), 5'($urandom), 6'($urandom), 6'($urandom), 3'($urandom),
           8'($urandom), 4'($urandom), 1'($urandom));
    if (sel < 42) begin
      c.op = sfe_pkg::OP_TICK;
    end else if (sel < 60) begin
      c.op = sfe_pkg::OP_SET;
      if ($urandom_range(0, 9) != 0) c.channel = 3'($urandom_range(0, sfe_pkg::CHANNELS - 1));
    end else if (sel < 75) begin
      c.op = sfe_pkg::OP_TIME;
      if ($urandom_range(0, 9) < 7) c.second = '0;
      if ($urandom_range(0, 9) < 7) begin
        pt = $urandom_range(0, sfe_pkg::POINTS - 1);
        c.hour   = sb.sched_time[pt].hour;
        c.minute = sb.sched_time[pt].minute;
      end
    end else if (sel < 83) begin
      c = mk_point_time(4'($urandom), ($urandom_range(0, 4) == 0) ? 5'($urandom) :
                        5'($urandom_range(0, 23)), ($urandom_range(0, 4) == 0) ?
                        6'($urandom) : 6'($urandom_range(0, 59)), 1'b1);
      if ($urandom_range(0, 4) == 0) c.enabled = 1'b0;
    end else if (sel < 97) begin
      c.op = sfe_pkg::OP_PT_DUTY;
      if ($urandom_range(0, 9) != 0) c.channel = 3'($urandom_range(0, sfe_pkg::CHANNELS - 1));
    end else begin
      c.op = 3'($urandom_range(5, 7));
    end
    return c;
  endfunction

  // Register write; only issued while the block is idle.
  task automatic write_reg(logic [sfe_pkg::CFG_IW-1:0] idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering and wait until every expected report has come, then let a
  // time event's schedule walk finish.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] pwm_set [4];
    logic [7:0]  steps_set [4];
    sb = new();
    no_idle = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    for (int j = 0; j < sfe_pkg::POINTS; j++)
      for (int k = 0; k < sfe_pkg::CHANNELS; k++) duty_written[j][k] = 1'b0;
    pwm_set   = '{16'd65535, 16'd1, 16'd0, 16'd255};
    steps_set = '{8'd1, 8'd255, 8'd0, 8'd7};
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.op <= sfe_pkg::OP_TICK;
    in_if.clock_hour <= '0;
    in_if.clock_minute <= '0;
    in_if.now_second <= '0;
    in_if.channel <= '0;
    in_if.duty <= '0;
    in_if.point_index <= '0;
    in_if.point_enabled <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= sfe_pkg::CFG_MAX_PWM;
    cfg_if.data <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: idle tick, schedule load, late point winning, ignored items.
    send(mk(sfe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < sfe_pkg::CHANNELS; k++)
      send(mk(sfe_pkg::OP_PT_DUTY, 0, 0, 0, 3'(k), (k % 2) ? 8'd255 : 8'd0, 4'd15, 0));
    for (int k = 0; k < sfe_pkg::CHANNELS; k++)
      send(mk(sfe_pkg::OP_PT_DUTY, 0, 0, 0, 3'(k), 8'(40 * k + 3), 4'd0, 0));
    send(mk(sfe_pkg::OP_PT_DUTY, 0, 0, 0, 3'd7, 8'd9, 4'd0, 0));
    send(mk_point_time(4'd0, 5'd1, 6'd0, 1'b1));
    send(mk_point_time(4'd15, 5'd0, 6'd60, 1'b1));
    send(mk(sfe_pkg::OP_TIME, 5'd1, 6'd0, 6'd30, 0, 0, 0, 0));
    send(mk(sfe_pkg::OP_TIME, 5'd0, 6'd60, 6'd0, 0, 0, 0, 0));
    send(mk(sfe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send(mk(sfe_pkg::OP_SET, 5'd31, 6'd63, 6'd63, 3'd7, 8'd255, 4'd15, 1'b1));
    send(mk(sfe_pkg::OP_SET, 0, 0, 0, 3'd1, 8'd255, 0, 0));
    send(mk(sfe_pkg::OP_SET, 0, 0, 0, 3'd4, 8'd255, 0, 0));
    send(mk(3'd5, 0, 0, 0, 0, 0, 0, 0));
    send(mk(3'd6, 0, 0, 0, 0, 0, 0, 0));
    send(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
    send(mk(sfe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send(mk_point_time(4'd3, 5'd31, 6'd63, 1'b0));

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(sfe_pkg::CFG_MAX_PWM, pwm_set[ph]);
      write_reg(sfe_pkg::CFG_FADE_STEPS, {8'd0, steps_set[ph]});
      no_idle = (ph == 2);
      if (ph == 1) hold_req <= 1'b1;
      for (int i = 0; i < 25; i++) send(rand_cmd());
      // Make sure each phase ends with a fade in flight to tick through.
      send(mk(sfe_pkg::OP_SET, 0, 0, 0, 3'($urandom_range(0, sfe_pkg::CHANNELS - 1)),
              8'($urandom), 0, 0));
      send(mk(sfe_pkg::OP_TIME, 0, 0, 6'd1, 0, 0, 0, 0));
      for (int i = 0; i < 6; i++) send(mk(sfe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    end
    no_idle = 1'b0;
    drain();

    $display("Ran %0d transactions: %0d active fade ticks, %0d schedule loads, %0d reports.",
             items_sent, sb.active_ticks, sb.loads, sb.reports_seen);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin : watchdog
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
